// File: design/roi_pkg.sv
// Shared types, register codes and pixel helpers for the window channel-peak block.
`timescale 1ns / 1ps

package roi_pkg;

    // Width of every configuration register and of the write data port.
    localparam int CFG_W = 12;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] IDX_WINDOW_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_WINDOW_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_WINDOW_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_WINDOW_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_FRAME_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] IDX_FRAME_HEIGHT  = 3'd5;

    // Register values after reset.
    localparam logic [CFG_W-1:0] RST_WINDOW_LEFT   = 12'd0;
    localparam logic [CFG_W-1:0] RST_WINDOW_TOP    = 12'd0;
    localparam logic [CFG_W-1:0] RST_WINDOW_WIDTH  = 12'd40;
    localparam logic [CFG_W-1:0] RST_WINDOW_HEIGHT = 12'd40;
    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH   = 12'd320;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT  = 12'd240;

    // Channel field masks of an RGB565 word.
    localparam logic [15:0] CH5_MASK = 16'h001F;
    localparam logic [15:0] CH6_MASK = 16'h003F;

    // Configuration registers as one bundle; the two start fields are two's complement.
    typedef struct packed {
        logic [CFG_W-1:0] window_left;
        logic [CFG_W-1:0] window_top;
        logic [CFG_W-1:0] window_width;
        logic [CFG_W-1:0] window_height;
        logic [CFG_W-1:0] frame_width;
        logic [CFG_W-1:0] frame_height;
    } cfg_t;

    // A classified pixel on its way from the front end to the peak tracker.
    typedef struct packed {
        logic       in_window;
        logic       last;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_item_t;

    // One frame result.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } peak_t;

    // Expand the 5-bit red field to 8 bits.
    function automatic logic [7:0] expand_red(logic [15:0] pix);
        logic [4:0] r;
        r = 5'((pix >> 11) & CH5_MASK);
        return {r, 3'b000};
    endfunction

    // Expand the 6-bit green field to 8 bits.
    function automatic logic [7:0] expand_green(logic [15:0] pix);
        logic [5:0] g;
        g = 6'((pix >> 5) & CH6_MASK);
        return {g, 2'b00};
    endfunction

    // Expand the 5-bit blue field to 8 bits.
    function automatic logic [7:0] expand_blue(logic [15:0] pix);
        logic [4:0] b;
        b = 5'(pix & CH5_MASK);
        return {b, 3'b000};
    endfunction

endpackage

// File: design/roi_rgb565_channel_max_top.sv
// Top level of the window channel-peak block: registers, queues and the two engines.
`timescale 1ns / 1ps

// Takes one RGB565 pixel per clock in raster order and tracks the largest
// expanded red, green and blue value inside a configurable window. The pixel
// flagged frame_end closes the frame: its result (the three peaks) is built by
// the back end and held in the result queue; the position counters restart at
// column 0, row 0. A front end classifies each pixel against the clipped window
// and a back end updates the peaks; a two-entry queue between them and another
// on the result side let either side stall alone, so input keeps flowing at one
// pixel per clock unless results are left unread. Configuration writes take
// effect on the next clock and should be made between frames.

module roi_rgb565_channel_max_top #(
    parameter int MAX_DIM = 2048
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [roi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [roi_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             push,
    output logic                             full,
    input  logic [15:0]                      rgb_pixel,
    input  logic                             frame_end,
    output logic                             empty,
    input  logic                             pop,
    output logic [7:0]                       peak_red,
    output logic [7:0]                       peak_green,
    output logic [7:0]                       peak_blue
);

    import roi_pkg::*;

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    pix_item_t front_item;
    pix_item_t back_item;
    logic      accept;
    logic      mid_empty;
    logic      mid_pop;
    logic      res_full;
    logic      res_push;
    peak_t     res_in;
    peak_t     res_out;

    // Configuration register file; unknown indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                IDX_WINDOW_LEFT:   cfg_next.window_left   = cfg_data;
                IDX_WINDOW_TOP:    cfg_next.window_top    = cfg_data;
                IDX_WINDOW_WIDTH:  cfg_next.window_width  = cfg_data;
                IDX_WINDOW_HEIGHT: cfg_next.window_height = cfg_data;
                IDX_FRAME_WIDTH:   cfg_next.frame_width   = cfg_data;
                IDX_FRAME_HEIGHT:  cfg_next.frame_height  = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_left   <= RST_WINDOW_LEFT;
            cfg_reg.window_top    <= RST_WINDOW_TOP;
            cfg_reg.window_width  <= RST_WINDOW_WIDTH;
            cfg_reg.window_height <= RST_WINDOW_HEIGHT;
            cfg_reg.frame_width   <= RST_FRAME_WIDTH;
            cfg_reg.frame_height  <= RST_FRAME_HEIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // A pixel transfer happens whenever push is high and the classified-pixel queue has room.
    assign accept = push && !full;

    roi_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (accept),
        .rgb_pixel (rgb_pixel),
        .frame_end (frame_end),
        .item      (front_item)
    );

    roi_fifo #(
        .W ($bits(pix_item_t))
    ) u_mid_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .data_in  (front_item),
        .full     (full),
        .pop      (mid_pop),
        .data_out (back_item),
        .empty    (mid_empty)
    );

    roi_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (!mid_empty),
        .item       (back_item),
        .item_pop   (mid_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res_in)
    );

    roi_fifo #(
        .W ($bits(peak_t))
    ) u_res_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_push),
        .data_in  (res_in),
        .full     (res_full),
        .pop      (pop),
        .data_out (res_out),
        .empty    (empty)
    );

    assign peak_red   = res_out.red;
    assign peak_green = res_out.green;
    assign peak_blue  = res_out.blue;

endmodule

// File: design/roi_fifo.sv
// Two-entry first-in first-out queue with registered storage.
`timescale 1ns / 1ps

module roi_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] data_in,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] data_out,
    output logic         empty
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         do_push;
    logic         do_pop;

    assign full     = count_reg[1];
    assign empty    = (count_reg == 2'd0);
    assign data_out = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // Pointer and occupancy update for each transfer.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset; an entry is read only after it was written.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= data_in;
        end
    end

endmodule

// File: design/roi_front.sv
// Front end: raster position counters, window test and channel expansion.
`timescale 1ns / 1ps

module roi_front #(
    parameter int MAX_DIM = 2048
) (
    input  logic               clk,
    input  logic               rst_n,
    input  roi_pkg::cfg_t      cfg,
    input  logic               accept,
    input  logic [15:0]        rgb_pixel,
    input  logic               frame_end,
    output roi_pkg::pix_item_t item
);

    import roi_pkg::*;

    localparam int CW = $clog2(MAX_DIM);
    localparam int EW = ((CW > CFG_W) ? CW : CFG_W) + 2;

    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [CW-1:0] row_reg;
    logic [CW-1:0] row_next;

    logic [EW-1:0] col_pos;
    logic [EW-1:0] col_start;
    logic [EW-1:0] col_sum;
    logic [EW-1:0] col_stop;
    logic [EW-1:0] row_pos;
    logic [EW-1:0] row_start;
    logic [EW-1:0] row_sum;
    logic [EW-1:0] row_stop;
    logic [EW-1:0] wrap;
    logic          col_hit;
    logic          row_hit;

    // Clip the window: a negative start becomes zero, the end stops at the image edge.
    always_comb
    begin
        col_pos   = EW'(col_reg);
        col_start = cfg.window_left[CFG_W-1] ? '0 : EW'(cfg.window_left);
        col_sum   = col_start + EW'(cfg.window_width);
        col_stop  = (col_sum > EW'(cfg.frame_width)) ? EW'(cfg.frame_width) : col_sum;
        col_hit   = (col_pos >= col_start) && (col_pos < col_stop);

        row_pos   = EW'(row_reg);
        row_start = cfg.window_top[CFG_W-1] ? '0 : EW'(cfg.window_top);
        row_sum   = row_start + EW'(cfg.window_height);
        row_stop  = (row_sum > EW'(cfg.frame_height)) ? EW'(cfg.frame_height) : row_sum;
        row_hit   = (row_pos >= row_start) && (row_pos < row_stop);
    end

    // Classified pixel handed to the queue.
    always_comb
    begin
        item.in_window = col_hit && row_hit;
        item.last      = frame_end;
        item.red       = expand_red(rgb_pixel);
        item.green     = expand_green(rgb_pixel);
        item.blue      = expand_blue(rgb_pixel);
    end

    // Raster position: the column wraps at the frame width (at most MAX_DIM),
    // the row saturates at its top value, and frame end clears both.
    always_comb
    begin
        wrap     = (EW'(cfg.frame_width) > EW'(MAX_DIM)) ? EW'(MAX_DIM)
                                                         : EW'(cfg.frame_width);
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if ((col_pos + EW'(1)) >= wrap)
            begin
                col_next = '0;
                if (row_reg < CW'(MAX_DIM - 1))
                begin
                    row_next = row_reg + CW'(1);
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// File: design/roi_back.sv
// Back end: running channel peaks and per-frame result hand-off.
`timescale 1ns / 1ps

module roi_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  roi_pkg::pix_item_t item,
    output logic               item_pop,
    input  logic               res_full,
    output logic               res_push,
    output roi_pkg::peak_t     res
);

    import roi_pkg::*;

    logic [7:0] red_reg;
    logic [7:0] red_next;
    logic [7:0] green_reg;
    logic [7:0] green_next;
    logic [7:0] blue_reg;
    logic [7:0] blue_next;
    logic [7:0] red_upd;
    logic [7:0] green_upd;
    logic [7:0] blue_upd;

    // A frame-end pixel waits until the result queue has room.
    assign item_pop = item_valid && (!item.last || !res_full);
    assign res_push = item_pop && item.last;

    // Compare and keep the maximum of each channel for window pixels.
    always_comb
    begin
        red_upd   = red_reg;
        green_upd = green_reg;
        blue_upd  = blue_reg;
        if (item.in_window)
        begin
            if (item.red > red_reg)
            begin
                red_upd = item.red;
            end
            if (item.green > green_reg)
            begin
                green_upd = item.green;
            end
            if (item.blue > blue_reg)
            begin
                blue_upd = item.blue;
            end
        end

        res.red   = red_upd;
        res.green = green_upd;
        res.blue  = blue_upd;

        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        if (item_pop)
        begin
            if (item.last)
            begin
                red_next   = '0;
                green_next = '0;
                blue_next  = '0;
            end
            else
            begin
                red_next   = red_upd;
                green_next = green_upd;
                blue_next  = blue_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_reg   <= '0;
            green_reg <= '0;
            blue_reg  <= '0;
        end
        else
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

endmodule

// File: design/roi_checker.sv
// Port-level checks of the window channel-peak block, bound to its top level.
`timescale 1ns / 1ps

module roi_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          push,
    input logic                          full,
    input logic                          frame_end,
    input logic                          empty,
    input logic                          pop,
    input logic [7:0]                    peak_red,
    input logic [7:0]                    peak_green,
    input logic [7:0]                    peak_blue
);

    logic [7:0] pend_reg;
    logic [7:0] pend_next;
    logic       frame_in;
    logic       res_out;

    assign frame_in = push && !full && frame_end;
    assign res_out  = pop && !empty;

    // Frames closed at the input whose results are not yet transferred out.
    always_comb
    begin
        pend_next = pend_reg;
        if (frame_in && !res_out)
        begin
            pend_next = pend_reg + 8'd1;
        end
        else if (res_out && !frame_in)
        begin
            pend_next = pend_reg - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // Every result belongs to a frame end that came in earlier.
    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (pend_reg != 8'd0))
        else $error("result shown without a pending frame end");

    // A waiting result stays and holds its value until it is taken.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(peak_red) && $stable(peak_green)
                              && $stable(peak_blue)))
        else $error("waiting result changed or vanished");

    // Peaks are expanded channel values, so their low bits are always zero.
    a_peak_expanded: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((peak_red[2:0] == 3'd0) && (peak_green[1:0] == 2'd0)
                    && (peak_blue[2:0] == 3'd0)))
        else $error("peak value is not an expanded channel");

    // With no frame pending and no result waiting, the input side is open.
    a_input_open: assert property (@(posedge clk) disable iff (!rst_n)
        ((pend_reg == 8'd0) && empty && $past(!push) && $past(!push, 2)
         && $past(!push, 3)) |-> !full)
        else $error("input blocked while the block is idle");

endmodule

bind roi_rgb565_channel_max_top roi_checker u_checker (.*);

// File: tb/tb_roi_rgb565_channel_max_top.sv
// Testbench for the window channel-peak block: directed table, random frames and a scoreboard.
`timescale 1ns / 1ps

module tb_roi_rgb565_channel_max_top;
    import roi_pkg::*;

    localparam int MAX_DIM = 2048;
    localparam int RANDOM_PIXELS = 1200;
    localparam int QUIET_AFTER = 1000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD = 250;
    localparam int CYCLE_LIMIT = 400000;

    // Indexes past the last register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    // One row of the directed table; want is used only where typed is set.
    typedef struct packed {
        logic [15:0] pix;
        logic        last_px;
        logic        typed;
        peak_t       want;
    } table_row_t;

    localparam int DIR_ROWS = 14;
    localparam table_row_t DIRECTED_TABLE [DIR_ROWS] = '{
        '{16'hFFFF, 1'b1, 1'b1, 24'hF8FCF8},
        '{16'h0000, 1'b1, 1'b1, 24'h000000},
        '{16'hF800, 1'b0, 1'b0, 24'h000000},
        '{16'h07E0, 1'b0, 1'b0, 24'h000000},
        '{16'h001F, 1'b1, 1'b1, 24'hF8FCF8},
        '{16'h0821, 1'b1, 1'b1, 24'h080408},
        '{16'hAAAA, 1'b0, 1'b0, 24'h000000},
        '{16'h5555, 1'b1, 1'b0, 24'h000000},
        '{16'h8410, 1'b0, 1'b0, 24'h000000},
        '{16'h7BEF, 1'b1, 1'b0, 24'h000000},
        '{16'hFFDF, 1'b0, 1'b0, 24'h000000},
        '{16'h0000, 1'b0, 1'b0, 24'h000000},
        '{16'hF81F, 1'b1, 1'b0, 24'h000000},
        '{16'h07FF, 1'b1, 1'b0, 24'h000000}
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 push;
    logic                 full;
    logic [15:0]          rgb_pixel;
    logic                 frame_end;
    logic                 empty;
    logic                 pop;
    logic [7:0]           peak_red;
    logic [7:0]           peak_green;
    logic [7:0]           peak_blue;

    // Predictor copy of the registers and the frame state.
    logic [CFG_W-1:0] cur_left;
    logic [CFG_W-1:0] cur_top;
    logic [CFG_W-1:0] cur_wwidth;
    logic [CFG_W-1:0] cur_wheight;
    logic [CFG_W-1:0] cur_fwidth;
    logic [CFG_W-1:0] cur_fheight;
    int unsigned      col_pos;
    int unsigned      row_pos;
    peak_t            running_peak;
    peak_t            peak_queue[$];

    int  errors = 0;
    int  pixels_sent = 0;
    int  frames_closed = 0;
    int  results_checked = 0;
    int  window_settings = 0;
    int  long_holds = 0;
    int  cycle_count = 0;
    bit  sender_idle = 1'b1;
    bit  receiver_idle = 1'b1;
    bit  hold_request = 1'b0;

    roi_rgb565_channel_max_top #(
        .MAX_DIM(MAX_DIM)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .push(push),
        .full(full),
        .rgb_pixel(rgb_pixel),
        .frame_end(frame_end),
        .empty(empty),
        .pop(pop),
        .peak_red(peak_red),
        .peak_green(peak_green),
        .peak_blue(peak_blue)
    );

    // Clock: 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // True when pos lies in the clipped span; a negative start moves to 0 and keeps its length.
    function automatic bit in_span(int unsigned pos, logic signed [CFG_W-1:0] start,
                                   logic [CFG_W-1:0] len, logic [CFG_W-1:0] limit);
        int lo;
        int hi;
        lo = start;
        if (lo < 0)
            lo = 0;
        hi = lo + int'(len);
        if (hi > int'(limit))
            hi = int'(limit);
        return int'(pos) >= lo && int'(pos) < hi;
    endfunction

    // Advance the predictor by one pixel; the frame-end pixel queues the three peaks.
    function automatic void track_pixel(logic [15:0] pix, logic last_px);
        int unsigned wrap;
        peak_t       px;
        wrap = (cur_fwidth > MAX_DIM) ? MAX_DIM : int'(cur_fwidth);
        px.red = {pix[15:11], 3'b000};
        px.green = {pix[10:5], 2'b00};
        px.blue = {pix[4:0], 3'b000};
        if (in_span(col_pos, cur_left, cur_wwidth, cur_fwidth) &&
            in_span(row_pos, cur_top, cur_wheight, cur_fheight))
        begin
            if (px.red > running_peak.red)
                running_peak.red = px.red;
            if (px.green > running_peak.green)
                running_peak.green = px.green;
            if (px.blue > running_peak.blue)
                running_peak.blue = px.blue;
        end
        if (last_px)
        begin
            peak_queue.push_back(running_peak);
            running_peak = '0;
            col_pos = 0;
            row_pos = 0;
            frames_closed++;
        end
        else if (col_pos + 1 >= wrap)
        begin
            col_pos = 0;
            if (row_pos < MAX_DIM - 1)
                row_pos++;
        end
        else
        begin
            col_pos++;
        end
    endfunction

    // Mirror a register write in the predictor; unused indexes are dropped.
    function automatic void note_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            IDX_WINDOW_LEFT:   cur_left = data;
            IDX_WINDOW_TOP:    cur_top = data;
            IDX_WINDOW_WIDTH:  cur_wwidth = data;
            IDX_WINDOW_HEIGHT: cur_wheight = data;
            IDX_FRAME_WIDTH:   cur_fwidth = data;
            IDX_FRAME_HEIGHT:  cur_fheight = data;
            default: ;
        endcase
    endfunction

    function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Score one result transfer against the oldest expectation.
    function automatic void check_result();
        peak_t want;
        if (peak_queue.size() == 0)
        begin
            $display("%0t: unexpected result: expected none, actual %h %h %h",
                     $time, peak_red, peak_green, peak_blue);
            errors++;
        end
        else
        begin
            want = peak_queue.pop_front();
            compare_field("peak_red", want.red, peak_red);
            compare_field("peak_green", want.green, peak_green);
            compare_field("peak_blue", want.blue, peak_blue);
        end
        results_checked++;
    endfunction

    // Pixel mix: half random, half all-ones, all-zeros and single-channel extremes.
    function automatic logic [15:0] pick_pixel();
        case ($urandom_range(0, 9))
            0: return 16'hFFFF;
            1: return 16'h0000;
            2: return 16'hF800;
            3: return 16'h07E0;
            4: return 16'h001F;
            default: return 16'($urandom);
        endcase
    endfunction

    // Register write; the caller lowers cfg_write after the last one of a batch.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        note_register(idx, data);
    endtask

    // Load a full window and frame setting, plus one write to an unused index.
    task automatic program_window(int left, int top, int ww, int wh, int fw, int fh);
        write_register(IDX_WINDOW_LEFT, CFG_W'(left));
        write_register(IDX_WINDOW_TOP, CFG_W'(top));
        write_register(IDX_WINDOW_WIDTH, CFG_W'(ww));
        write_register(IDX_WINDOW_HEIGHT, CFG_W'(wh));
        write_register(IDX_FRAME_WIDTH, CFG_W'(fw));
        write_register(IDX_FRAME_HEIGHT, CFG_W'(fh));
        write_register($urandom_range(0, 1) ? IDX_SPARE_HI : IDX_SPARE_LO, CFG_W'($urandom));
        cfg_write <= 1'b0;
        window_settings++;
    endtask

    // Offer one pixel, with an optional idle burst first, and wait for its transfer.
    task automatic send_pixel(logic [15:0] pix, logic last_px);
        if (sender_idle && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        push <= 1'b1;
        rgb_pixel <= pix;
        frame_end <= last_px;
        do @(posedge clk); while (full);
        track_pixel(pix, last_px);
        pixels_sent++;
    endtask

    task automatic send_frame(int len, bit closed);
        for (int i = 0; i < len; i++)
            send_pixel(pick_pixel(), closed && (i == len - 1));
    endtask

    // Stop offering, wait for all results, then let the pipeline settle.
    task automatic drain_block();
        push <= 1'b0;
        while (peak_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: random stalls, one long hold on request, and scoring of each transfer.
    initial
    begin
        int hold_left;
        pop = 1'b0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                check_result();
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
                long_holds++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (receiver_idle && $urandom_range(0, 5) == 0)
            begin
                hold_left = $urandom_range(0, 7);
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Main sequence: reset, directed table, special settings, pressure, random frames.
    initial
    begin
        int random_start;
        int fw;
        int rows;
        int fh;
        int left;
        int top;
        int ww;
        int wh;
        int len;

        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = IDX_WINDOW_LEFT;
        cfg_data = '0;
        push = 1'b0;
        rgb_pixel = '0;
        frame_end = 1'b0;
        cur_left = RST_WINDOW_LEFT;
        cur_top = RST_WINDOW_TOP;
        cur_wwidth = RST_WINDOW_WIDTH;
        cur_wheight = RST_WINDOW_HEIGHT;
        cur_fwidth = RST_FRAME_WIDTH;
        cur_fheight = RST_FRAME_HEIGHT;
        col_pos = 0;
        row_pos = 0;
        running_peak = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under the reset setting.
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            send_pixel(DIRECTED_TABLE[i].pix, DIRECTED_TABLE[i].last_px);
            if (DIRECTED_TABLE[i].typed)
                peak_queue[$] = DIRECTED_TABLE[i].want;
        end
        drain_block();

        // Negative start keeps its width; rows clip at the frame height.
        program_window(-3, -2048, 6, 4095, 8, 4);
        repeat (3) send_frame(32, 1'b1);
        drain_block();

        // Zero window width, then zero window height.
        program_window(2, 1, 0, 5, 8, 8);
        repeat (2) send_frame(64, 1'b1);
        drain_block();
        program_window(0, 0, 8, 0, 8, 8);
        repeat (2) send_frame(64, 1'b1);
        drain_block();

        // Frame width zero: every pixel starts a new row and none is in the window.
        program_window(0, 0, 40, 40, 0, 240);
        repeat (2) send_frame(20, 1'b1);
        drain_block();

        // Window entirely past the right image edge.
        program_window(30, 0, 10, 10, 16, 8);
        repeat (2) send_frame(128, 1'b1);
        drain_block();

        // Register extremes.
        program_window(2047, 2047, 4095, 4095, 4095, 4095);
        send_frame(16, 1'b1);
        drain_block();
        program_window(-2048, -2048, 4095, 4095, 4, 4);
        send_frame(16, 1'b1);
        drain_block();

        // Receiver holds off for a long stretch while single-pixel frames keep coming.
        program_window(0, 0, 40, 40, 320, 240);
        hold_request = 1'b1;
        repeat (40) send_frame(1, 1'b1);
        drain_block();

        // Random settings with mostly well-formed frames; the tail runs without idling.
        random_start = pixels_sent;
        while (pixels_sent - random_start < RANDOM_PIXELS)
        begin
            if (pixels_sent - random_start >= QUIET_AFTER)
            begin
                sender_idle = 1'b0;
                receiver_idle = 1'b0;
            end
            case ($urandom_range(0, 19))
                0, 1:    fw = 0;
                2:       fw = 4095;
                default: fw = $urandom_range(1, 12);
            endcase
            rows = $urandom_range(1, 10);
            fh = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : rows;
            left = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) - 2048
                                               : $urandom_range(0, 16) - 4;
            top = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) - 2048
                                              : $urandom_range(0, 12) - 3;
            ww = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 12);
            wh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 10);
            program_window(left, top, ww, wh, fw, fh);
            repeat ($urandom_range(1, 4))
            begin
                len = (fw == 0 || fw > 16) ? $urandom_range(1, 24) : fw * rows;
                case ($urandom_range(0, 7))
                    0: len = $urandom_range(1, len);
                    1: len = len + $urandom_range(1, 12);
                    default: ;
                endcase
                send_frame(len, 1'b1);
            end
            // Now and then a frame is left open across the next setting change.
            if ($urandom_range(0, 7) == 0)
                send_frame($urandom_range(1, 10), 1'b0);
            drain_block();
        end

        $display("Covered %0d pixels in %0d frames over %0d window settings,", pixels_sent,
                 frames_closed, window_settings);
        $display("with %0d result transfers checked and %0d long receiver hold(s).",
                 results_checked, long_holds);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
design/roi_pkg.sv
design/roi_fifo.sv
design/roi_front.sv
design/roi_back.sv
design/roi_rgb565_channel_max_top.sv
design/roi_checker.sv
tb/tb_roi_rgb565_channel_max_top.sv
